// ===== hdl/mlpfwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlpfwd_pkg: shared types, constants and table function
// Item structs, pipeline tags and the sigmoid table entry generator used by
// the perceptron forward unit.
// ---------------------------------------------------------------------------
package mlpfwd_pkg;

  // default sizes of the network
  localparam int NInputDef  = 3;
  localparam int NHiddenDef = 8;
  localparam int NOutputDef = 3;
  localparam int SigDepthDef = 256;

  // fixed widths (field widths and the parameter ranges settle these)
  localparam int WordW = 16;
  localparam int AddrW = 6;
  localparam int NeurW = 4;   // neuron index, up to 16 hidden neurons
  localparam int TermW = 5;   // term index within a neuron, bias included
  localparam int OpW   = 18;  // signed operand: Q4.12 input, Q0.16 hidden, bias scale
  localparam int ProdW = OpW + WordW;
  localparam int AccW  = 40;

  // bias scale factors per layer
  localparam int HidBiasScale = 4096;
  localparam int OutBiasScale = 65536;

  // func codes
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncEval = 1'b1;

  // layer codes
  localparam logic LayerHidden = 1'b0;
  localparam logic LayerOutput = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [AddrW-1:0]        weight_index;
    logic signed [WordW-1:0] weight_value;
    logic signed [WordW-1:0] in_a;
    logic signed [WordW-1:0] in_b;
    logic signed [WordW-1:0] in_c;
  } req_item_t;

  typedef struct packed {
    logic [WordW-1:0] out_a;
    logic [WordW-1:0] out_b;
    logic [WordW-1:0] out_c;
  } rsp_item_t;

  // one term issued by the sequencer
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic             layer;
    logic [TermW-1:0] term;
    logic [NeurW-1:0] neuron;
    logic             first;
    logic             last;
    logic             last_neuron;
  } issue_t;

  // neuron tag carried down the activation path
  typedef struct packed {
    logic             valid;
    logic             layer;
    logic [NeurW-1:0] neuron;
    logic             last_neuron;
  } tag_t;

  typedef struct packed {
    tag_t                   tag;
    logic signed [AccW-1:0] acc;
  } acc_t;

  typedef struct packed {
    tag_t             tag;
    logic [WordW-1:0] value;
  } act_t;

  // Unsigned shift-and-subtract division for elaboration-time tables.
  // Operands are nonnegative and below 2^63.
  function automatic longint udiv(input longint num, input longint den);
    longint rem;
    longint quo;
    rem = 0;
    quo = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & longint'(1));
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | longint'(1);
      end
    end
    return quo;
  endfunction

  // Sigmoid at the center of bin idx of a depth-entry table over [-8,8),
  // Q0.16. Evaluated at elaboration only.
  function automatic logic [WordW-1:0] sig_entry(input int idx, input int depth);
    longint c;
    longint m;
    longint u;
    longint sum;
    longint term;
    longint e;
    longint q;
    longint v;
    c = 2 * longint'(idx) + 1 - longint'(depth);
    m = (c < 0) ? -c : c;
    u = udiv(m << 30, longint'(depth));
    sum  = 0;
    term = longint'(1) << 31;
    for (int k = 0; k < 24; k++) begin
      if (k > 0) begin
        term = udiv((term * u) >> 31, longint'(k));
      end
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = sum;
    for (int k = 0; k < 4; k++) begin
      e = (e * e) >> 31;
    end
    q = (longint'(1) << 31) + e;
    if (c >= 0) begin
      v = udiv((longint'(1) << 47) + (q >> 1), q);
    end else begin
      v = udiv((e << 16) + (q >> 1), q);
    end
    if (v > 65535) begin
      v = 65535;
    end
    return v[WordW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mlpfwd_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlpfwd_seq: evaluation sequencer
// Walks the weight words of all neurons, one term per cycle with a pause
// between the layers, and tracks the block's busy, flush and delivery phases.
// ---------------------------------------------------------------------------
module mlpfwd_seq
  import mlpfwd_pkg::*;
#(
  parameter int NInput  = NInputDef,
  parameter int NHidden = NHiddenDef,
  parameter int NOutput = NOutputDef
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire logic   fin,
  input  wire logic   out_free,
  output issue_t      issue,
  output logic        idle,
  output logic        deliver
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRun   = 3'd1;
  localparam logic [2:0] StWait  = 3'd2;
  localparam logic [2:0] StFlush = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  // hidden results must be written back before the output layer reads them
  localparam logic [2:0] DrainCycles = 3'd6;

  logic [2:0]       state;
  logic             layer;
  logic [NeurW-1:0] neuron;
  logic [TermW-1:0] term;
  logic [AddrW-1:0] addr;
  logic [2:0]       wait_cnt;
  logic             last_term;
  logic             last_neu;

  always_comb begin
    if (layer == LayerHidden) begin
      last_term = (term == TermW'(NInput));
      last_neu  = (neuron == NeurW'(NHidden - 1));
    end else begin
      last_term = (term == TermW'(NHidden));
      last_neu  = (neuron == NeurW'(NOutput - 1));
    end
  end

  always_comb begin
    issue.valid       = (state == StRun);
    issue.addr        = addr;
    issue.layer       = layer;
    issue.term        = term;
    issue.neuron      = neuron;
    issue.first       = (term == '0);
    issue.last        = last_term;
    issue.last_neuron = last_neu;
  end

  assign idle    = (state == StIdle);
  assign deliver = (state == StDone) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= StIdle;
      layer    <= LayerHidden;
      neuron   <= '0;
      term     <= '0;
      addr     <= '0;
      wait_cnt <= '0;
    end else begin
      case (state)
        StIdle: begin
          if (start) begin
            state  <= StRun;
            layer  <= LayerHidden;
            neuron <= '0;
            term   <= '0;
            addr   <= '0;
          end
        end
        StRun: begin
          addr <= addr + 1'b1;
          if (last_term) begin
            term <= '0;
            if (last_neu) begin
              neuron <= '0;
              if (layer == LayerHidden) begin
                layer    <= LayerOutput;
                wait_cnt <= DrainCycles;
                state    <= StWait;
              end else begin
                state <= StFlush;
              end
            end else begin
              neuron <= neuron + 1'b1;
            end
          end else begin
            term <= term + 1'b1;
          end
        end
        StWait: begin
          if (wait_cnt == '0) begin
            state <= StRun;
          end else begin
            wait_cnt <= wait_cnt - 1'b1;
          end
        end
        StFlush: begin
          if (fin) begin
            state <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mlpfwd_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlpfwd_mac: weight store and shared multiply-accumulate
// Holds the weight memory, the latched inputs and the hidden values, and
// accumulates one neuron's terms into a wide signed sum.
// ---------------------------------------------------------------------------
module mlpfwd_mac
  import mlpfwd_pkg::*;
#(
  parameter int NHidden = NHiddenDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [AddrW-1:0]        wr_addr,
  input  wire logic [WordW-1:0]        wr_data,
  input  wire logic                    start,
  input  wire logic signed [WordW-1:0] x_a,
  input  wire logic signed [WordW-1:0] x_b,
  input  wire logic signed [WordW-1:0] x_c,
  input  wire issue_t                  issue,
  input  wire act_t                    hid_wr,
  output acc_t                         acc_out
);

  localparam int StoreDepth = 1 << AddrW;
  localparam int HidW = (NHidden > 1) ? $clog2(NHidden) : 1;

  logic [WordW-1:0]        wmem [StoreDepth];
  logic [WordW-1:0]        rdata;
  logic signed [WordW-1:0] x_a_q;
  logic signed [WordW-1:0] x_b_q;
  logic signed [WordW-1:0] x_c_q;
  logic [WordW-1:0]        hid [NHidden];
  logic signed [OpW-1:0]   op;
  logic signed [OpW-1:0]   op_q;
  issue_t                  s1;
  issue_t                  s2;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  acc;
  tag_t                    acc_tag;

  // weight memory: written by load items, read one word a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[wr_addr] <= wr_data;
    end
    rdata <= wmem[issue.addr];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_a_q <= x_a;
      x_b_q <= x_b;
      x_c_q <= x_c;
    end
    if (hid_wr.tag.valid && (hid_wr.tag.layer == LayerHidden)) begin
      hid[hid_wr.tag.neuron[HidW-1:0]] <= hid_wr.value;
    end
  end

  // operand for the term being issued
  always_comb begin
    if (issue.layer == LayerHidden) begin
      if (issue.last) begin
        op = OpW'(HidBiasScale);
      end else if (issue.term == TermW'(0)) begin
        op = {{(OpW - WordW){x_a_q[WordW-1]}}, x_a_q};
      end else if (issue.term == TermW'(1)) begin
        op = {{(OpW - WordW){x_b_q[WordW-1]}}, x_b_q};
      end else begin
        op = {{(OpW - WordW){x_c_q[WordW-1]}}, x_c_q};
      end
    end else begin
      if (issue.last) begin
        op = OpW'(OutBiasScale);
      end else begin
        op = {{(OpW - WordW){1'b0}}, hid[issue.term[HidW-1:0]]};
      end
    end
  end

  assign prod_ext = {{(AccW - ProdW){prod[ProdW-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid       <= 1'b0;
      s2.valid       <= 1'b0;
      acc_tag.valid  <= 1'b0;
    end else begin
      s1            <= issue;
      s2            <= s1;
      acc_tag.valid <= s2.valid && s2.last;
    end
    op_q                <= op;
    prod                <= ProdW'(op_q) * ProdW'($signed(rdata));
    acc_tag.layer       <= s2.layer;
    acc_tag.neuron      <= s2.neuron;
    acc_tag.last_neuron <= s2.last_neuron;
    if (s2.valid) begin
      acc <= s2.first ? prod_ext : acc + prod_ext;
    end
  end

  assign acc_out.tag = acc_tag;
  assign acc_out.acc = acc;

endmodule
`default_nettype wire

// ===== hdl/mlpfwd_act.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlpfwd_act: sigmoid activation
// Saturates a neuron sum to [-8,8) in Q4.12, scales it to a table index and
// looks the sigmoid up, three register stages.
// ---------------------------------------------------------------------------
module mlpfwd_act
  import mlpfwd_pkg::*;
#(
  parameter int SigDepth = SigDepthDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire acc_t acc_in,
  output act_t      act_out
);

  localparam int IdxW = $clog2(SigDepth);
  localparam int DepW = $clog2(SigDepth + 1);
  localparam int ScW  = WordW + DepW;

  localparam logic signed [AccW-1:0] HidLim = AccW'(longint'(1) << 27);
  localparam logic signed [AccW-1:0] OutLim = AccW'(longint'(1) << 31);

  logic [WordW-1:0]       rom [SigDepth];
  logic signed [AccW-1:0] lim;
  logic signed [AccW-1:0] shifted;
  logic [WordW-1:0]       p;
  logic [WordW-1:0]       p_q;
  logic [ScW-1:0]         scaled;
  logic [IdxW-1:0]        idx_q;
  tag_t                   tag_p;
  tag_t                   tag_i;
  tag_t                   tag_v;
  logic [WordW-1:0]       value;

  for (genvar g = 0; g < SigDepth; g++) begin : g_rom
    localparam logic [WordW-1:0] Entry = sig_entry(g, SigDepth);
    assign rom[g] = Entry;
  end

  // saturate and drop the fraction bits below Q4.12
  always_comb begin
    lim     = (acc_in.tag.layer == LayerHidden) ? HidLim : OutLim;
    shifted = acc_in.acc + lim;
    if (acc_in.acc < -lim) begin
      p = '0;
    end else if (acc_in.acc > lim - 1) begin
      p = '1;
    end else if (acc_in.tag.layer == LayerHidden) begin
      p = shifted[27:12];
    end else begin
      p = shifted[31:16];
    end
  end

  assign scaled = ScW'(p_q) * ScW'(SigDepth);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p.valid <= 1'b0;
      tag_i.valid <= 1'b0;
      tag_v.valid <= 1'b0;
    end else begin
      tag_p <= acc_in.tag;
      tag_i <= tag_p;
      tag_v <= tag_i;
    end
    p_q   <= p;
    idx_q <= scaled[WordW +: IdxW];
    value <= rom[idx_q];
  end

  assign act_out.tag   = tag_v;
  assign act_out.value = value;

endmodule
`default_nettype wire

// ===== hdl/mlp_3_8_3_sigmoid_forward_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlp_3_8_3_sigmoid_forward_unit: perceptron forward pass, sigmoid layers
// Fully connected NInput-NHidden-NOutput network in fixed point with one
// shared multiply-accumulate and a sigmoid lookup table.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries items. func = load
//   writes weight_value to word weight_index of the weight store; loads
//   stream back to back while the block is idle. func = eval runs the
//   network on in_a..in_c and returns one rsp item.
//   Weight layout: per hidden neuron NInput weights then its bias, then per
//   output neuron NHidden weights then its bias (59 words at 3-8-3).
//   The shared multiply-accumulate takes one weight word per cycle while
//   the sequencer runs; a drain between the layers lets the last hidden
//   value reach the hidden registers.
//   req_stall is high from an eval accept until its result moves to the
//   rsp register, so evaluations run one at a time.
//   The rsp register holds a finished item while rsp_stall is high; a new
//   item (load or eval) is still taken meanwhile. A finished eval waits for
//   the rsp register to empty before the block goes idle again.
//   Reset clears the sequencer and valid flags; the weight store is not
//   cleared, every word must be loaded before an eval reads it.
// ---------------------------------------------------------------------------
module mlp_3_8_3_sigmoid_forward_unit
  import mlpfwd_pkg::*;
#(
  parameter int NInput   = NInputDef,
  parameter int NHidden  = NHiddenDef,
  parameter int NOutput  = NOutputDef,
  parameter int SigDepth = SigDepthDef
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp
);

  logic             accept;
  logic             wr_en;
  logic             start;
  logic             idle;
  logic             deliver;
  logic             fin;
  logic             out_free;
  issue_t           issue;
  acc_t             acc;
  act_t             act;
  logic [WordW-1:0] work_a;
  logic [WordW-1:0] work_b;
  logic [WordW-1:0] work_c;

  // an item only enters while the sequencer is idle
  assign req_stall = !idle;
  assign accept    = req_valid && !req_stall;
  assign wr_en     = accept && (req.func == FuncLoad);
  assign start     = accept && (req.func == FuncEval);

  // last output neuron written back means the result is complete
  assign fin      = act.tag.valid && (act.tag.layer == LayerOutput) && act.tag.last_neuron;
  assign out_free = !rsp_valid || !rsp_stall;

  mlpfwd_seq #(
    .NInput  (NInput),
    .NHidden (NHidden),
    .NOutput (NOutput)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .fin      (fin),
    .out_free (out_free),
    .issue    (issue),
    .idle     (idle),
    .deliver  (deliver)
  );

  mlpfwd_mac #(
    .NHidden (NHidden)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (req.weight_index),
    .wr_data (req.weight_value),
    .start   (start),
    .x_a     (req.in_a),
    .x_b     (req.in_b),
    .x_c     (req.in_c),
    .issue   (issue),
    .hid_wr  (act),
    .acc_out (acc)
  );

  mlpfwd_act #(
    .SigDepth (SigDepth)
  ) u_act (
    .clk     (clk),
    .rst     (rst),
    .acc_in  (acc),
    .act_out (act)
  );

  // collect output neuron values as they come out of the table
  always_ff @(posedge clk) begin
    if (act.tag.valid && (act.tag.layer == LayerOutput)) begin
      case (act.tag.neuron)
        NeurW'(0): work_a <= act.value;
        NeurW'(1): work_b <= act.value;
        NeurW'(2): work_c <= act.value;
        default: begin
        end
      endcase
    end
  end

  // result register; output neurons not present read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (deliver) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (deliver) begin
      rsp.out_a <= (NOutput > 0) ? work_a : '0;
      rsp.out_b <= (NOutput > 1) ? work_b : '0;
      rsp.out_c <= (NOutput > 2) ? work_c : '0;
    end
  end

endmodule
`default_nettype wire
